// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared property shapes for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define MSS_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define MSS_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/msstat_pkg.sv -----
// ----------------------------------------------------------------------------
// msstat_pkg
// types and fixed widths of the masked stack statistics block
// ----------------------------------------------------------------------------
package msstat_pkg;

    localparam int SAMPLE_W = 24;
    localparam int LC_W     = 9;
    localparam int SUM_W    = 32;
    localparam int SQ_W     = 56;
    localparam int VAR_W    = 47;
    localparam int DEV_W    = 23;
    localparam int MEAN_W   = 33;
    localparam int EXT_W    = 34;

    localparam int DIV_W    = 64;
    localparam int DVS_W    = 17;
    localparam int STEP_W   = 7;
    localparam int RAD_W    = 48;
    localparam int ROOT_W   = 24;
    localparam int SQC_W    = 5;

    localparam logic [STEP_W-1:0] MEAN_STEPS = 7'd32;
    localparam logic [STEP_W-1:0] VAR_STEPS  = 7'd64;

    localparam logic [LC_W-1:0]  LAYER_COUNT_RESET = 9'd2;
    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};
    localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       sample_missing;
    } sample_t;

    typedef struct packed {
        logic                       stats_valid;
        logic [LC_W-1:0]            valid_count;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
        logic [VAR_W-1:0]           variance_value;
        logic [DEV_W-1:0]           std_dev;
        logic signed [SAMPLE_W-1:0] mean_minus_dev;
        logic signed [SAMPLE_W-1:0] mean_plus_dev;
    } result_t;

    typedef struct packed {
        logic              go;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic             go;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// ----- hw/rtl/msstat_div.sv -----
// ----------------------------------------------------------------------------
// msstat_div
// restoring shift-subtract divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module msstat_div
    import msstat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVS_W:0]    rem_shift;
    logic [DVS_W:0]    rem_diff;
    logic              ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        ge        = rem_shift >= {1'b0, dvs_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.go)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops
            rem_next = ge ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- hw/rtl/msstat_sqrt.sv -----
// ----------------------------------------------------------------------------
// msstat_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module msstat_sqrt
    import msstat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SQC_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W+1:0]  rem_t;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  rem_sub;
    logic              ge;

    always_comb
    begin
        rem_t   = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial   = {2'b00, root_reg, 2'b01};
        rem_sub = rem_t - trial;
        ge      = rem_t >= trial;

        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.go)
        begin
            rad_next  = req.radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = SQC_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[REM_W-1:0] : rem_t[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

// ----- hw/rtl/masked_stack_statistics_top.sv -----
// a request that does not close a cell keeps busy high through S_SQ and S_ACC; a new
// request is taken only back in idle; the request that closes a cell with data keeps busy
// high through five passes of the shared 32x32 multiplier, a 32-step mean divide, a 64-step
// variance divide and a 24-step square root; a cell with no data finishes in S_ACC
// done pulses one cycle with the result, which cannot be held off
// rst_n clears the accumulators and sets layer_count to 2
// ----------------------------------------------------------------------------
// masked_stack_statistics_top
// per-cell count, mean, variance, standard deviation, min, max and mean +/-
// deviation over a stack of samples with no-data flags
// ----------------------------------------------------------------------------
module masked_stack_statistics_top
    import msstat_pkg::*;
#(
    parameter int MAX_LAYERS  = 256,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  sample_t     sample,

    output logic        done,
    output result_t     result,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(MAX_LAYERS + 1);
    localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;
    localparam logic [LC_W-1:0] LIMIT_MAX = LC_W'(MAX_LAYERS);
    localparam logic [LC_W-1:0] LIMIT_MIN = 9'd2;
    localparam logic signed [EXT_W-1:0] SMAX =
        EXT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] SMIN = -SMAX - 1;

    localparam logic REG_LAYER_COUNT = 1'b0;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_M1    = 4'd3;
    localparam logic [3:0] S_M2    = 4'd4;
    localparam logic [3:0] S_M3    = 4'd5;
    localparam logic [3:0] S_M4    = 4'd6;
    localparam logic [3:0] S_M5    = 4'd7;
    localparam logic [3:0] S_DMEAN = 4'd8;
    localparam logic [3:0] S_DVAR  = 4'd9;
    localparam logic [3:0] S_SQRT  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]                 state_reg, state_next;
    logic [LC_W-1:0]            layer_count_reg, layer_count_next;
    logic [CNT_W-1:0]           seen_reg, seen_next;
    logic [CNT_W-1:0]           good_reg, good_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]            sumsq_reg, sumsq_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic [SAMPLE_W-1:0]        zabs_reg, zabs_next;
    logic                       miss_reg, miss_next;
    logic [63:0]                prod_reg;
    logic [63:0]                num_reg, num_next;
    logic [63:0]                sq_reg, sq_next;
    logic [DVS_W-1:0]           nn_reg, nn_next;
    logic signed [MEAN_W-1:0]   mean_reg, mean_next;
    logic [VAR_W-1:0]           var_reg, var_next;
    logic [DEV_W-1:0]           dev_reg, dev_next;
    logic                       done_reg, done_next;
    result_t                    result_reg, result_next;

    logic signed [SAMPLE_W-1:0] z_shl;
    logic signed [SAMPLE_W-1:0] z;
    logic [SUM_W-1:0]           sum_abs;
    logic [LC_W-1:0]            limit;
    logic [31:0]                mul_a, mul_b;
    logic [MEAN_W-1:0]          q_ext;
    logic [VAR_W-1:0]           var_clamp;
    logic signed [EXT_W-1:0]    mean_ext, dev_ext;
    logic                       cfg_write;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    function automatic logic [SAMPLE_W-1:0] sat_fn(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] r;
        begin
            r = v;
            if (v > SMAX)
            begin
                r = SMAX;
            end
            else if (v < SMIN)
            begin
                r = SMIN;
            end
            sat_fn = r[SAMPLE_W-1:0];
        end
    endfunction

    msstat_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    msstat_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // only the low SAMPLE_BITS bits count, as two's complement
    always_comb
    begin
        z_shl   = sample.sample_value <<< SHIFT;
        z       = z_shl >>> SHIFT;
        sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

        if (layer_count_reg < LIMIT_MIN)
        begin
            limit = LIMIT_MIN;
        end
        else if (layer_count_reg > LIMIT_MAX)
        begin
            limit = LIMIT_MAX;
        end
        else
        begin
            limit = layer_count_reg;
        end

        q_ext     = {1'b0, div_rsp.quotient[31:0]};
        var_clamp = (div_rsp.quotient > 64'(VAR_MAX)) ? VAR_MAX
                                                       : div_rsp.quotient[VAR_W-1:0];
        mean_ext  = EXT_W'(mean_reg);
        dev_ext   = signed'(EXT_W'(dev_reg));
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = 32'(zabs_reg);
                mul_b = 32'(zabs_reg);
            end
            S_M1:
            begin
                mul_a = 32'(good_reg);
                mul_b = sumsq_reg[31:0];
            end
            S_M2:
            begin
                mul_a = 32'(good_reg);
                mul_b = 32'(sumsq_reg[SQ_W-1:32]);
            end
            S_M3:
            begin
                mul_a = sum_abs;
                mul_b = sum_abs;
            end
            S_M4:
            begin
                mul_a = 32'(good_reg);
                mul_b = 32'(good_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_req.go       = (state_reg == S_M5) || (state_reg == S_DMEAN && div_rsp.done);
        div_req.dividend = (state_reg == S_M5) ? {sum_abs, 32'd0} : num_reg;
        div_req.divisor  = (state_reg == S_M5) ? DVS_W'(good_reg) : nn_reg;
        div_req.steps    = (state_reg == S_M5) ? MEAN_STEPS : VAR_STEPS;

        sqrt_req.go       = (state_reg == S_DVAR) && div_rsp.done;
        sqrt_req.radicand = RAD_W'(var_clamp);
    end

    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_LAYER_COUNT);

    always_comb
    begin
        state_next       = state_reg;
        layer_count_next = cfg_write ? pwdata[LC_W-1:0] : layer_count_reg;
        seen_next        = seen_reg;
        good_next        = good_reg;
        sum_next         = sum_reg;
        sumsq_next       = sumsq_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        zabs_next        = zabs_reg;
        miss_next        = miss_reg;
        num_next         = num_reg;
        sq_next          = sq_reg;
        nn_next          = nn_reg;
        mean_next        = mean_reg;
        var_next         = var_reg;
        dev_next         = dev_reg;
        done_next        = 1'b0;
        result_next      = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    seen_next = seen_reg + 1'b1;
                    miss_next = sample.sample_missing;
                    zabs_next = z[SAMPLE_W-1] ? SAMPLE_W'(-z) : SAMPLE_W'(z);
                    if (!sample.sample_missing)
                    begin
                        good_next = good_reg + 1'b1;
                        sum_next  = sum_reg + SUM_W'(z);
                        if (good_reg == '0)
                        begin
                            min_next = z;
                            max_next = z;
                        end
                        else if (z < min_reg)
                        begin
                            min_next = z;
                        end
                        else if (z > max_reg)
                        begin
                            max_next = z;
                        end
                    end
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (!miss_reg)
                begin
                    sumsq_next = sumsq_reg + SQ_W'(prod_reg[47:0]);
                end
                if (LC_W'(seen_reg) >= limit)
                begin
                    if (good_reg == '0)
                    begin
                        result_next = '0;
                        done_next   = 1'b1;
                        seen_next   = '0;
                        sumsq_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_M1;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_M1:
            begin
                state_next = S_M2;
            end
            S_M2:
            begin
                num_next   = prod_reg;
                state_next = S_M3;
            end
            S_M3:
            begin
                // n * sumsq stays below 2^63
                num_next   = num_reg + {prod_reg[31:0], 32'd0};
                state_next = S_M4;
            end
            S_M4:
            begin
                sq_next    = prod_reg;
                state_next = S_M5;
            end
            S_M5:
            begin
                nn_next    = prod_reg[DVS_W-1:0];
                num_next   = (num_reg > sq_reg) ? (num_reg - sq_reg) : 64'd0;
                state_next = S_DMEAN;
            end
            S_DMEAN:
            begin
                if (div_rsp.done)
                begin
                    // negative sum rounds the magnitude up so the mean is a floor
                    if (sum_reg[SUM_W-1])
                    begin
                        mean_next = -signed'(q_ext + MEAN_W'(|div_rsp.remainder));
                    end
                    else
                    begin
                        mean_next = signed'(q_ext);
                    end
                    state_next = S_DVAR;
                end
            end
            S_DVAR:
            begin
                if (div_rsp.done)
                begin
                    var_next   = var_clamp;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_rsp.done)
                begin
                    dev_next = (sqrt_rsp.root > ROOT_W'(DEV_MAX)) ? DEV_MAX
                                                                  : sqrt_rsp.root[DEV_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                result_next.stats_valid    = 1'b1;
                result_next.valid_count    = LC_W'(good_reg);
                result_next.mean_value     = sat_fn(mean_ext);
                result_next.min_value      = min_reg;
                result_next.max_value      = max_reg;
                result_next.variance_value = var_reg;
                result_next.std_dev        = dev_reg;
                result_next.mean_minus_dev = sat_fn(mean_ext - dev_ext);
                result_next.mean_plus_dev  = sat_fn(mean_ext + dev_ext);
                done_next  = 1'b1;
                seen_next  = '0;
                good_next  = '0;
                sum_next   = '0;
                sumsq_next = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            layer_count_reg <= LAYER_COUNT_RESET;
            seen_reg        <= '0;
            good_reg        <= '0;
            sum_reg         <= '0;
            sumsq_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            layer_count_reg <= layer_count_next;
            seen_reg        <= seen_next;
            good_reg        <= good_next;
            sum_reg         <= sum_next;
            sumsq_reg       <= sumsq_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg    <= min_next;
        max_reg    <= max_next;
        zabs_reg   <= zabs_next;
        miss_reg   <= miss_next;
        prod_reg   <= mul_a * mul_b;
        num_reg    <= num_next;
        sq_reg     <= sq_next;
        nn_reg     <= nn_next;
        mean_reg   <= mean_next;
        var_reg    <= var_next;
        dev_reg    <= dev_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LAYER_COUNT) ? 32'(layer_count_reg) : 32'd0;

endmodule

// ----- hw/rtl/msstat_checker.sv -----
// ----------------------------------------------------------------------------
// msstat_checker
// port-level checks on the masked stack statistics block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msstat_checker
    import msstat_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // a result only shows once the work on its request is over
    `MSS_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

    // an accepted request always raises busy and brings no result with it
    `MSS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)

    // a cell with no data reports zeros
    `MSS_ASSERT_IMP(a_empty_zero, clk, rst_n, done && !result.stats_valid,
        result.valid_count == '0 && result.variance_value == '0 && result.std_dev == '0)

    // floor mean lies between the extremes
    `MSS_ASSERT_IMP(a_mean_range, clk, rst_n, done && result.stats_valid,
        result.min_value <= result.mean_value && result.mean_value <= result.max_value)

endmodule

bind masked_stack_statistics_top msstat_checker u_msstat_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- verif/masked_stack_statistics_top_test.sv -----
// ----------------------------------------------------------------------------
// masked_stack_statistics_top_test
// drives layer samples into the stack statistics block, predicts each cell's
// count, mean, variance, deviation, min and max and checks every result
// ----------------------------------------------------------------------------
module masked_stack_statistics_top_test;
    import msstat_pkg::*;

    localparam int          MAX_LAYERS       = 256;
    localparam int          CYCLE_LIMIT      = 1_000_000;
    localparam int          SETTLE_CYCLES    = 12;
    localparam int          TAIL_CYCLES      = 160;
    localparam logic [2:0]  LAYER_COUNT_ADDR = 3'd0;
    localparam longint      SAMPLE_MAX       = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint      SAMPLE_MIN       = -SAMPLE_MAX - 1;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

    localparam int NUM_PHASES = 6;
    localparam int PHASE_LC[NUM_PHASES]    = '{0, 3, 1, 256, 511, 7};
    localparam int PHASE_ITEMS[NUM_PHASES] = '{150, 150, 100, 276, 236, 60};
    localparam int PHASE_IDLE[NUM_PHASES]  = '{6, 0, 6, 6, 6, 6};

    typedef enum int {
        FILL_WIDE,
        FILL_CLUSTER,
        FILL_EMPTY,
        FILL_EXTREME,
        FILL_SPARSE
    } fill_mode_t;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    sample_t     sample  = '0;
    logic        done;
    result_t     result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    sample_t     pending[$];
    result_t     stats_due[$];
    result_t     next_due;
    int          idle_pct    = 6;
    int          mismatches  = 0;
    int          cycle_count = 0;

    // predictor copy of the register and the per-cell accumulators
    logic [LC_W-1:0]    layer_cfg = LAYER_COUNT_RESET;
    int                 seen_cnt  = 0;
    int                 good_cnt  = 0;
    longint             acc_sum   = 0;
    longint unsigned    acc_sq    = 0;
    longint             lo_val    = 0;
    longint             hi_val    = 0;

    fill_mode_t         fill_mode    = FILL_WIDE;
    logic [SAMPLE_W-1:0] cluster_base = '0;

    masked_stack_statistics_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .sample  (sample),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int effective_layers(logic [LC_W-1:0] v);
        int lim;
        lim = v;
        if (lim < 2)
            lim = 2;
        if (lim > MAX_LAYERS)
            lim = MAX_LAYERS;
        return lim;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip_sample(longint v);
        if (v > SAMPLE_MAX)
            return S_MAX;
        if (v < SAMPLE_MIN)
            return S_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    // bit-by-bit root, largest r with r*r <= x
    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic result_t cell_stats();
        result_t         r;
        longint unsigned n;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned sq;
        longint unsigned var_q;
        longint unsigned dev;
        longint          avg;
        r = '0;
        if (good_cnt != 0)
        begin
            n   = good_cnt;
            mag = (acc_sum < 0) ? -acc_sum : acc_sum;
            // mean rounds toward minus infinity
            if (acc_sum >= 0)
                avg = longint'(mag / n);
            else
                avg = -longint'((mag + n - 1) / n);
            num   = n * acc_sq;
            sq    = mag * mag;
            var_q = (num > sq) ? (num - sq) / (n * n) : 64'd0;
            if (var_q > VAR_MAX)
                var_q = VAR_MAX;
            dev = floor_root(var_q);
            if (dev > DEV_MAX)
                dev = DEV_MAX;
            r.stats_valid    = 1'b1;
            r.valid_count    = n[LC_W-1:0];
            r.mean_value     = clip_sample(avg);
            r.min_value      = lo_val[SAMPLE_W-1:0];
            r.max_value      = hi_val[SAMPLE_W-1:0];
            r.variance_value = var_q[VAR_W-1:0];
            r.std_dev        = dev[DEV_W-1:0];
            r.mean_minus_dev = clip_sample(avg - longint'(dev));
            r.mean_plus_dev  = clip_sample(avg + longint'(dev));
        end
        return r;
    endfunction

    task automatic accumulate_layer(input sample_t s);
        longint z;
        if (!s.sample_missing)
        begin
            z = $signed(s.sample_value);
            if (good_cnt == 0)
            begin
                lo_val = z;
                hi_val = z;
            end
            else
            begin
                if (z < lo_val)
                    lo_val = z;
                if (z > hi_val)
                    hi_val = z;
            end
            acc_sum += z;
            acc_sq  += longint'(z * z);
            good_cnt++;
        end
        seen_cnt++;
        // a lowered layer count closes the cell on the next request
        if (seen_cnt >= effective_layers(layer_cfg))
        begin
            stats_due.push_back(cell_stats());
            seen_cnt = 0;
            good_cnt = 0;
            acc_sum  = 0;
            acc_sq   = 0;
        end
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic sample_t pick_sample();
        sample_t s;
        s.sample_value   = SAMPLE_W'($urandom());
        s.sample_missing = ($urandom_range(99) < 10);
        case (fill_mode)
            FILL_CLUSTER:
                s.sample_value = SAMPLE_W'(cluster_base + $urandom_range(63));
            FILL_EMPTY:
                s.sample_missing = 1'b1;
            FILL_EXTREME:
                case ($urandom_range(4))
                    0:       s.sample_value = S_MAX;
                    1:       s.sample_value = S_MIN;
                    2:       s.sample_value = '0;
                    3:       s.sample_value = '1;
                    default: s.sample_value = 24'sd1;
                endcase
            FILL_SPARSE:
                s.sample_missing = 1'($urandom_range(1));
            default:
                ;
        endcase
        return s;
    endfunction

    task automatic fill_random(input int cnt, input int lim);
        int run_left;
        run_left = 0;
        for (int i = 0; i < cnt; i++)
        begin
            if (run_left == 0)
            begin
                fill_mode    = fill_mode_t'($urandom_range(FILL_SPARSE));
                cluster_base = SAMPLE_W'($urandom());
                run_left     = (lim <= 8) ? lim : $urandom_range(40, 1);
            end
            pending.push_back(pick_sample());
            run_left--;
        end
    endtask

    task automatic write_layer_count(input logic [LC_W-1:0] v);
        logic [31:0] wd;
        wd = $urandom();
        wd[LC_W-1:0] = v;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LAYER_COUNT_ADDR;
        pwdata  <= wd;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        layer_cfg = v;
        // read back the register once the write has landed
        @(posedge clk);
        check_field("prdata", 64'(v), 64'(prdata));
    endtask

    // all requests in, all results out, then let a request without result finish
    task automatic settle_idle();
        while (pending.size() != 0 || start || stats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start  <= 1'b0;
            sample <= '0;
        end
        else
        begin
            if (start && !busy)
                accumulate_layer(sample);
            if (!(start && busy))
            begin
                if (pending.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    sample <= pending.pop_front();
                    start  <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (stats_due.size() == 0)
            begin
                $error("result with no request pending");
                mismatches++;
            end
            else
            begin
                next_due = stats_due.pop_front();
                check_field("stats_valid", 64'(next_due.stats_valid),
                            64'(result.stats_valid));
                check_field("valid_count", 64'(next_due.valid_count),
                            64'(result.valid_count));
                check_field("mean_value", 64'(next_due.mean_value), 64'(result.mean_value));
                check_field("min_value", 64'(next_due.min_value), 64'(result.min_value));
                check_field("max_value", 64'(next_due.max_value), 64'(result.max_value));
                check_field("variance_value", 64'(next_due.variance_value),
                            64'(result.variance_value));
                check_field("std_dev", 64'(next_due.std_dev), 64'(result.std_dev));
                check_field("mean_minus_dev", 64'(next_due.mean_minus_dev),
                            64'(result.mean_minus_dev));
                check_field("mean_plus_dev", 64'(next_due.mean_plus_dev),
                            64'(result.mean_plus_dev));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** masked_stack_statistics_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // two-layer cells at the reset count: extremes, flat, empty, one valid
        pending.push_back(sample_t'{S_MAX, 1'b0});
        pending.push_back(sample_t'{S_MAX, 1'b0});
        pending.push_back(sample_t'{S_MIN, 1'b0});
        pending.push_back(sample_t'{S_MIN, 1'b0});
        pending.push_back(sample_t'{S_MAX, 1'b0});
        pending.push_back(sample_t'{S_MIN, 1'b0});
        pending.push_back(sample_t'{S_MAX, 1'b1});
        pending.push_back(sample_t'{S_MIN, 1'b1});
        pending.push_back(sample_t'{S_MIN, 1'b1});
        pending.push_back(sample_t'{-24'sd1, 1'b0});
        pending.push_back(sample_t'{24'sd1, 1'b0});
        pending.push_back(sample_t'{24'sd0, 1'b0});
        settle_idle();

        // four-layer cells that push mean +/- deviation into saturation
        write_layer_count(9'd4);
        pending.push_back(sample_t'{S_MIN, 1'b0});
        pending.push_back(sample_t'{S_MAX, 1'b0});
        pending.push_back(sample_t'{S_MAX, 1'b0});
        pending.push_back(sample_t'{S_MAX, 1'b0});
        pending.push_back(sample_t'{S_MAX, 1'b0});
        pending.push_back(sample_t'{S_MIN, 1'b0});
        pending.push_back(sample_t'{S_MIN, 1'b0});
        pending.push_back(sample_t'{S_MIN, 1'b0});
        // partial cell, closed by the next request after the count drops
        pending.push_back(sample_t'{24'sd5, 1'b0});
        pending.push_back(sample_t'{-24'sd7, 1'b0});
        pending.push_back(sample_t'{24'sd3, 1'b1});
        settle_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_layer_count(LC_W'(PHASE_LC[p]));
            idle_pct = PHASE_IDLE[p];
            fill_random(PHASE_ITEMS[p], effective_layers(LC_W'(PHASE_LC[p])));
            settle_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** masked_stack_statistics_top: PASSED **");
        else
            $display("** masked_stack_statistics_top: FAILED **");
        $finish;
    end

endmodule
